### src/b64ml_pkg.sv
// ----------------------------------------------------------------------------
// b64ml_pkg: shared types and constants of the base64 MIME line encoder
// Job descriptor passed from the front end to the character sequencer,
// character codes, line geometry and the sequencer state encoding.
// ----------------------------------------------------------------------------
package b64ml_pkg;

   // Line geometry: a line end follows the first group reaching LINE_CHARS
   localparam int LINE_CHARS      = 76;
   localparam int GROUPS_PER_LINE = (LINE_CHARS + 3) / 4;
   localparam int COL_W           = 6;

   // Character codes
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // Input item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_TEXT_MODE     = 1'b0;
   localparam logic CSR_CRLF_LINE_END = 1'b1;

   // Job queue between front end and sequencer
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One unit of output work: an optional four-character group, an optional
   // line end after it, and an optional final line end.
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  pad_count;
      logic        has_group;
      logic        line_break;
      logic        final_end;
   } job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_GRP0,
      BK_GRP1,
      BK_GRP2,
      BK_GRP3,
      BK_BRK_CR,
      BK_BRK_LF,
      BK_FIN_CR,
      BK_FIN_LF
   } back_state_type;

   // Standard base64 alphabet
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] ext;
      ext = {2'b00, v};
      if (v < 6'd26) begin
         b64_char = 8'(8'd65 + ext);
      end else if (v < 6'd52) begin
         b64_char = 8'(8'd71 + ext);
      end else if (v < 6'd62) begin
         b64_char = 8'(ext - 8'd4);
      end else if (v == 6'd62) begin
         b64_char = 8'h2B;
      end else begin
         b64_char = 8'h2F;
      end
   endfunction

endpackage

### src/base64_mime_line_encoder.sv
// ----------------------------------------------------------------------------
// base64_mime_line_encoder: streaming base64 encoder with MIME line breaking
// Top level: configuration registers, front end, job queue, sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per input item: req_kind 0 is a data byte in
//   req_data_byte, req_kind 1 ends the stream (flush with '=' padding and a
//   final line end). rsp_* carries one output character per beat, with
//   rsp_last_of_run set on the final character an item causes. A data byte
//   that does not complete a group of three causes no beat at all.
//   csr_write_en/csr_index/csr_wdata write text_mode (index 0) and
//   crlf_line_end (index 1); write them only while the block is idle.
// Timing:
//   With the sequencer idle, an accepted item passes the job queue, the
//   sequencer state and the output register before its first character is
//   on rsp. The sequencer emits one character per cycle unless rsp stalls;
//   a completed group causes 4 characters, 5-6 with a line end, an end item
//   up to 8. Group-filling bytes go one per cycle while req_stall is low.
// Reset and stall:
//   Synchronous reset clears the stream state, the queue, the sequencer and
//   both registers. A stall on rsp holds the output beat; the two-entry job
//   queue keeps req open until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module base64_mime_line_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   logic               text_mode_ff;
   logic               crlf_line_end_ff;
   logic               job_push;
   b64ml_pkg::job_type front_job;
   logic               queue_full;
   logic               head_valid;
   b64ml_pkg::job_type head_job;
   logic               job_pop;

   // Configuration registers: plain write, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff     <= 1'b0;
         crlf_line_end_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            b64ml_pkg::CSR_TEXT_MODE:     text_mode_ff     <= csr_wdata;
            b64ml_pkg::CSR_CRLF_LINE_END: crlf_line_end_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Hold req while the job queue has no room
   assign req_stall = queue_full;

   // Front end: classify each beat, update group and column state
   b64ml_front u_front (
      .clock         (clock),
      .reset         (reset),
      .text_mode     (text_mode_ff),
      .req_valid     (req_valid),
      .req_stall     (queue_full),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .job_push      (job_push),
      .job           (front_job)
   );

   // Queue: lets the front end run on while the sequencer is stalled
   b64ml_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (front_job),
      .pop        (job_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back end: advance one character per beat into the output register
   b64ml_back u_back (
      .clock           (clock),
      .reset           (reset),
      .crlf_line_end   (crlf_line_end_ff),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (job_pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### src/b64ml_front.sv
// ----------------------------------------------------------------------------
// b64ml_front: input classification and stream state
// Applies text-mode CR insertion, gathers bytes into groups, tracks the line
// column and turns each accepted item into at most one output job.
// ----------------------------------------------------------------------------
module b64ml_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               text_mode,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_kind,
   input  logic [7:0]         req_data_byte,
   output logic               job_push,
   output b64ml_pkg::job_type job
);

   logic [15:0]                  pend_bytes_ff, pend_bytes_in;
   logic [1:0]                   pend_count_ff, pend_count_in;
   logic [b64ml_pkg::COL_W-1:0] col_groups_ff, col_groups_in;
   logic                         prev_cr_ff, prev_cr_in;

   logic                         accept;
   logic                         insert_cr;
   logic [7:0]                   first_byte;
   logic [2:0]                   total;
   logic [b64ml_pkg::COL_W-1:0] col_inc;
   logic                         col_wrap;
   logic                         job_needed;

   assign accept = req_valid && !req_stall;

   always_comb begin
      insert_cr  = text_mode && (req_data_byte == b64ml_pkg::CHAR_LF) && !prev_cr_ff;
      first_byte = insert_cr ? b64ml_pkg::CHAR_CR : req_data_byte;
      total      = {1'b0, pend_count_ff} + (insert_cr ? 3'd2 : 3'd1);
      col_inc    = b64ml_pkg::COL_W'(col_groups_ff + 1'b1);
      col_wrap   = (col_inc >= b64ml_pkg::COL_W'(b64ml_pkg::GROUPS_PER_LINE));

      job           = '0;
      job_needed    = 1'b0;
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      col_groups_in = col_groups_ff;
      prev_cr_in    = prev_cr_ff;

      if (req_kind == b64ml_pkg::KIND_END) begin
         // flush: pad any partial group, always close with a line end
         job_needed    = 1'b1;
         job.final_end = 1'b1;
         case (pend_count_ff)
            2'd1: begin
               job.word       = {pend_bytes_ff[7:0], 16'h0000};
               job.pad_count  = 2'd2;
               job.has_group  = 1'b1;
               job.line_break = col_wrap;
            end
            2'd2: begin
               job.word       = {pend_bytes_ff, 8'h00};
               job.pad_count  = 2'd1;
               job.has_group  = 1'b1;
               job.line_break = col_wrap;
            end
            default: begin
            end
         endcase
         pend_bytes_in = '0;
         pend_count_in = '0;
         col_groups_in = '0;
         prev_cr_in    = 1'b0;
      end else begin
         prev_cr_in = (req_data_byte == b64ml_pkg::CHAR_CR);
         if (total >= 3'd3) begin
            job_needed     = 1'b1;
            job.has_group  = 1'b1;
            job.line_break = col_wrap;
            job.word       = (pend_count_ff == 2'd2) ? {pend_bytes_ff, first_byte}
                                                      : {pend_bytes_ff[7:0], first_byte,
                                                         req_data_byte};
            col_groups_in  = col_wrap ? '0 : col_inc;
            if (total == 3'd4) begin
               // inserted CR closed the group, the LF starts the next one
               pend_bytes_in = {8'h00, req_data_byte};
               pend_count_in = 2'd1;
            end else begin
               pend_bytes_in = '0;
               pend_count_in = '0;
            end
         end else begin
            pend_bytes_in = insert_cr ? {b64ml_pkg::CHAR_CR, req_data_byte}
                                      : {pend_bytes_ff[7:0], req_data_byte};
            pend_count_in = total[1:0];
         end
      end
   end

   assign job_push = accept && job_needed;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_count_ff <= '0;
         col_groups_ff <= '0;
         prev_cr_ff    <= 1'b0;
      end else if (accept) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
         col_groups_ff <= col_groups_in;
         prev_cr_ff    <= prev_cr_in;
      end
   end

endmodule

### src/b64ml_queue.sv
// ----------------------------------------------------------------------------
// b64ml_queue: short job queue
// Decouples the front end from the character sequencer.
// ----------------------------------------------------------------------------
module b64ml_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64ml_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output b64ml_pkg::job_type head_job
);

   b64ml_pkg::job_type                 entry_ff [b64ml_pkg::QUEUE_DEPTH];
   logic [b64ml_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b64ml_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b64ml_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == b64ml_pkg::QUEUE_PTR_W'(b64ml_pkg::QUEUE_DEPTH - 1))
                   ? '0 : b64ml_pkg::QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == b64ml_pkg::QUEUE_PTR_W'(b64ml_pkg::QUEUE_DEPTH - 1))
                   ? '0 : b64ml_pkg::QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = b64ml_pkg::QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = b64ml_pkg::QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   assign full       = (count_ff == b64ml_pkg::QUEUE_CNT_W'(b64ml_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule

### src/b64ml_back.sv
// ----------------------------------------------------------------------------
// b64ml_back: character sequencer
// Walks each job one character per beat into a registered output stage.
// ----------------------------------------------------------------------------
module b64ml_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               crlf_line_end,
   input  logic               head_valid,
   input  b64ml_pkg::job_type head_job,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last_of_run
);

   b64ml_pkg::back_state_type state_ff, state_in, state_nxt;
   b64ml_pkg::job_type        job_ff, job_in;
   logic                      rsp_valid_ff;
   logic [7:0]                rsp_char_ff;
   logic                      rsp_last_ff;
   logic                      advance;
   logic                      emit;
   logic [7:0]                char_cur;
   logic                      last_cur;

   function automatic b64ml_pkg::back_state_type fin_first(input logic crlf);
      fin_first = crlf ? b64ml_pkg::BK_FIN_CR : b64ml_pkg::BK_FIN_LF;
   endfunction

   function automatic b64ml_pkg::back_state_type first_phase(
      input b64ml_pkg::job_type j, input logic crlf);
      first_phase = j.has_group ? b64ml_pkg::BK_GRP0 : fin_first(crlf);
   endfunction

   function automatic b64ml_pkg::back_state_type next_phase(
      input b64ml_pkg::back_state_type st, input b64ml_pkg::job_type j, input logic crlf);
      unique case (st)
         b64ml_pkg::BK_GRP0: next_phase = b64ml_pkg::BK_GRP1;
         b64ml_pkg::BK_GRP1: next_phase = b64ml_pkg::BK_GRP2;
         b64ml_pkg::BK_GRP2: next_phase = b64ml_pkg::BK_GRP3;
         b64ml_pkg::BK_GRP3: begin
            if (j.line_break) begin
               next_phase = crlf ? b64ml_pkg::BK_BRK_CR : b64ml_pkg::BK_BRK_LF;
            end else if (j.final_end) begin
               next_phase = fin_first(crlf);
            end else begin
               next_phase = b64ml_pkg::BK_IDLE;
            end
         end
         b64ml_pkg::BK_BRK_CR: next_phase = b64ml_pkg::BK_BRK_LF;
         b64ml_pkg::BK_BRK_LF: next_phase = j.final_end ? fin_first(crlf)
                                                         : b64ml_pkg::BK_IDLE;
         b64ml_pkg::BK_FIN_CR: next_phase = b64ml_pkg::BK_FIN_LF;
         default:              next_phase = b64ml_pkg::BK_IDLE;
      endcase
   endfunction

   assign advance = !rsp_valid_ff || !rsp_stall;

   // next state: load a job when idle, chain straight into the next one
   always_comb begin
      state_nxt = next_phase(state_ff, job_ff, crlf_line_end);
      state_in  = state_ff;
      job_in    = job_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      if (state_ff == b64ml_pkg::BK_IDLE) begin
         if (head_valid) begin
            pop      = 1'b1;
            job_in   = head_job;
            state_in = first_phase(head_job, crlf_line_end);
         end
      end else if (advance) begin
         emit = 1'b1;
         if ((state_nxt == b64ml_pkg::BK_IDLE) && head_valid) begin
            pop      = 1'b1;
            job_in   = head_job;
            state_in = first_phase(head_job, crlf_line_end);
         end else begin
            state_in = state_nxt;
         end
      end
   end

   // outputs: character of the current phase
   always_comb begin
      last_cur = (state_nxt == b64ml_pkg::BK_IDLE);
      unique case (state_ff)
         b64ml_pkg::BK_GRP0: char_cur = b64ml_pkg::b64_char(job_ff.word[23:18]);
         b64ml_pkg::BK_GRP1: char_cur = b64ml_pkg::b64_char(job_ff.word[17:12]);
         b64ml_pkg::BK_GRP2: char_cur = (job_ff.pad_count == 2'd2) ? b64ml_pkg::CHAR_PAD
                                        : b64ml_pkg::b64_char(job_ff.word[11:6]);
         b64ml_pkg::BK_GRP3: char_cur = (job_ff.pad_count != 2'd0) ? b64ml_pkg::CHAR_PAD
                                        : b64ml_pkg::b64_char(job_ff.word[5:0]);
         b64ml_pkg::BK_BRK_CR,
         b64ml_pkg::BK_FIN_CR: char_cur = b64ml_pkg::CHAR_CR;
         b64ml_pkg::BK_BRK_LF,
         b64ml_pkg::BK_FIN_LF: char_cur = b64ml_pkg::CHAR_LF;
         default:              char_cur = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         rsp_char_ff <= char_cur;
         rsp_last_ff <= last_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b64ml_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_pad_never_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_char_ff == b64ml_pkg::CHAR_PAD)) |-> !rsp_last_ff)
      else $error("padding character closed a run");

   // a CR only comes from a line end, and an LF always follows it
   a_cr_never_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_char_ff == b64ml_pkg::CHAR_CR)) |-> !rsp_last_ff)
      else $error("run closed with a CR");

   a_cr_only_in_crlf: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == b64ml_pkg::BK_BRK_CR) || (state_ff == b64ml_pkg::BK_FIN_CR))
      |-> crlf_line_end)
      else $error("CR phase reached with LF-only line ends");

endmodule

### sim/base64_mime_line_encoder_checker.sv
// ----------------------------------------------------------------------------
// base64_mime_line_encoder_checker: output checker for the base64 line encoder
// Tracks every accepted byte, end beat and register write, builds the
// characters the encoder must produce, and compares each output beat
// against the oldest character still owed.
// ----------------------------------------------------------------------------
module base64_mime_line_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_last_of_run,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic       csr_wdata,
   output int         fail_count,
   output int         chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } out_beat_type;

   logic         text_on;
   logic         crlf_on;
   logic [15:0]  held_bytes;
   logic [1:0]   held_count;
   logic [5:0]   groups_on_line;
   logic         after_cr;
   logic [7:0]   item_chars[$];
   out_beat_type owed_chars[$];

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return ALPHABET[8 * (63 - int'(v)) +: 8];
   endfunction

   task automatic add_char(input logic [7:0] c);
      if (item_chars.size() < 8) begin
         item_chars.push_back(c);
      end
   endtask

   task automatic add_line_end();
      if (crlf_on) begin
         add_char(b64ml_pkg::CHAR_CR);
      end
      add_char(b64ml_pkg::CHAR_LF);
   endtask

   // break the line after the first group that reaches the column limit
   task automatic finish_group();
      groups_on_line = groups_on_line + 6'd1;
      if (int'(groups_on_line) * 4 >= b64ml_pkg::LINE_CHARS) begin
         add_line_end();
         groups_on_line = '0;
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      logic [23:0] word;
      after_cr = (b == b64ml_pkg::CHAR_CR);
      if (held_count >= 2'd2) begin
         word = {held_bytes, b};
         add_char(sextet_char(word[23:18]));
         add_char(sextet_char(word[17:12]));
         add_char(sextet_char(word[11:6]));
         add_char(sextet_char(word[5:0]));
         held_bytes = '0;
         held_count = '0;
         finish_group();
      end else begin
         held_bytes = {held_bytes[7:0], b};
         held_count = held_count + 2'd1;
      end
   endtask

   task automatic close_stream();
      logic [7:0] c1;
      logic [7:0] c2;
      c1 = held_bytes[15:8];
      c2 = held_bytes[7:0];
      if (held_count == 2'd1) begin
         add_char(sextet_char(c2[7:2]));
         add_char(sextet_char({c2[1:0], 4'b0000}));
         add_char(b64ml_pkg::CHAR_PAD);
         add_char(b64ml_pkg::CHAR_PAD);
         finish_group();
      end else if (held_count >= 2'd2) begin
         add_char(sextet_char(c1[7:2]));
         add_char(sextet_char({c1[1:0], c2[7:4]}));
         add_char(sextet_char({c2[3:0], 2'b00}));
         add_char(b64ml_pkg::CHAR_PAD);
         finish_group();
      end
      add_line_end();
      held_bytes     = '0;
      held_count     = '0;
      groups_on_line = '0;
      after_cr       = 1'b0;
   endtask

   task automatic encode_item(input logic kind, input logic [7:0] b);
      out_beat_type beat;
      item_chars.delete();
      if (kind == b64ml_pkg::KIND_END) begin
         close_stream();
      end else begin
         if (text_on && b == b64ml_pkg::CHAR_LF && !after_cr) begin
            take_byte(b64ml_pkg::CHAR_CR);
         end
         take_byte(b);
      end
      foreach (item_chars[i]) begin
         beat.code = item_chars[i];
         beat.last = (i == item_chars.size() - 1);
         owed_chars.push_back(beat);
      end
   endtask

   task automatic report(input string what, input int want, input int got);
      fail_count++;
      $display("%0t ns: %s expected %02h, got %02h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      out_beat_type want;
      if (reset) begin
         text_on        = 1'b0;
         crlf_on        = 1'b0;
         held_bytes     = '0;
         held_count     = '0;
         groups_on_line = '0;
         after_cr       = 1'b0;
         fail_count     = 0;
         owed_chars.delete();
      end else begin
         // output side first: a beat leaving now cannot stem from this edge's input
         if (rsp_valid && !rsp_stall) begin
            if (owed_chars.size() == 0) begin
               report("no character owed, out_char", 0, rsp_out_char);
            end else begin
               want = owed_chars.pop_front();
               if (rsp_out_char !== want.code) begin
                  report("out_char", want.code, rsp_out_char);
               end
               if (rsp_last_of_run !== want.last) begin
                  report("last_of_run", want.last, rsp_last_of_run);
               end
            end
         end
         if (req_valid && !req_stall) begin
            encode_item(req_kind, req_data_byte);
         end
         if (csr_write_en) begin
            if (csr_index == b64ml_pkg::CSR_TEXT_MODE) begin
               text_on = csr_wdata;
            end else begin
               crlf_on = csr_wdata;
            end
         end
      end
      chars_pending = owed_chars.size();
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the base64 MIME line encoder
// Drives byte streams and end beats into the encoder under several register
// settings and idle/stall mixes, including a long output hold-off that
// backs the encoder up; the checker module predicts and compares every
// output character.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 20;
   localparam int SETTLE      = 20;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_kind;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;
   logic       csr_write_en;
   logic       csr_index;
   logic       csr_wdata;

   int fail_count;
   int chars_pending;
   int items_sent         = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;

   base64_mime_line_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   base64_mime_line_encoder_checker char_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .chars_pending   (chars_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Output side: random stall at the current rate, or a long hold-off when
   // the stimulus asks for one. The hold-off is counted here, in cycles.
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // Offer one beat, idling first at the current rate; hold the payload until
   // the encoder takes it. Valid stays high on return so back-to-back beats
   // never drop it.
   task automatic send_item(input logic kind, input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid     = 1'b0;
         req_kind      = 1'($urandom_range(1));
         req_data_byte = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_kind      = kind;
      req_data_byte = b;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // Bias toward line feeds and carriage returns so text mode gets exercised.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0, 1:    return b64ml_pkg::CHAR_LF;
         2:       return b64ml_pkg::CHAR_CR;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_stream(input int len, input logic with_end);
      for (int i = 0; i < len; i++) begin
         send_item(b64ml_pkg::KIND_DATA, pick_byte());
      end
      if (with_end) begin
         send_item(b64ml_pkg::KIND_END, 8'($urandom_range(255)));
      end
   endtask

   // Drop valid, wait for every owed character, then give the encoder time
   // to finish any beat that owes nothing.
   task automatic wait_for_quiet();
      req_valid = 1'b0;
      while (chars_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic value);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   initial begin
      int goal;
      int len;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = b64ml_pkg::KIND_DATA;
      req_data_byte = 8'h00;
      csr_write_en  = 1'b0;
      csr_index     = b64ml_pkg::CSR_TEXT_MODE;
      csr_wdata     = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: plain mode, LF line ends.
      write_reg(b64ml_pkg::CSR_TEXT_MODE, 1'b0);
      write_reg(b64ml_pkg::CSR_CRLF_LINE_END, 1'b0);
      send_item(b64ml_pkg::KIND_END, 8'hFF);      // empty stream: line end only
      send_item(b64ml_pkg::KIND_DATA, 8'h00);
      send_item(b64ml_pkg::KIND_DATA, 8'hFF);
      send_item(b64ml_pkg::KIND_DATA, 8'h00);
      send_item(b64ml_pkg::KIND_DATA, 8'hFF);
      send_item(b64ml_pkg::KIND_DATA, 8'hFF);
      send_item(b64ml_pkg::KIND_DATA, 8'hFF);
      send_item(b64ml_pkg::KIND_END, 8'h00);
      send_item(b64ml_pkg::KIND_DATA, 8'hFC);     // one byte left: two pad chars
      send_item(b64ml_pkg::KIND_END, 8'h00);
      send_item(b64ml_pkg::KIND_DATA, 8'h03);     // two bytes left: one pad char
      send_item(b64ml_pkg::KIND_DATA, 8'hF0);
      send_item(b64ml_pkg::KIND_END, 8'h00);
      wait_for_quiet();

      // Directed: text mode with CR LF line ends; bare LF, CR LF, LF after LF.
      write_reg(b64ml_pkg::CSR_TEXT_MODE, 1'b1);
      write_reg(b64ml_pkg::CSR_CRLF_LINE_END, 1'b1);
      send_item(b64ml_pkg::KIND_DATA, b64ml_pkg::CHAR_LF);
      send_item(b64ml_pkg::KIND_DATA, b64ml_pkg::CHAR_CR);
      send_item(b64ml_pkg::KIND_DATA, b64ml_pkg::CHAR_LF);
      send_item(b64ml_pkg::KIND_DATA, b64ml_pkg::CHAR_LF);
      send_item(b64ml_pkg::KIND_END, 8'h00);
      send_item(b64ml_pkg::KIND_END, 8'h00);      // new stream ends at once
      send_item(b64ml_pkg::KIND_DATA, b64ml_pkg::CHAR_LF);   // LF opening a fresh stream
      send_item(b64ml_pkg::KIND_END, 8'h00);
      wait_for_quiet();

      // Random streams; each phase its own register setting and idle mix.
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(b64ml_pkg::CSR_TEXT_MODE, phase[0]);
         write_reg(b64ml_pkg::CSR_CRLF_LINE_END, phase[1]);
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 71;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 71;
            end
            default: begin
               sender_idle_pct    = 27;
               receiver_stall_pct = 27;
            end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            case ($urandom_range(5))
               0:       len = 57;            // exactly one full line
               1:       len = $urandom_range(45, 70);
               default: len = $urandom_range(0, 8);
            endcase
            // keep each phase near its item budget
            if (len > goal - items_sent) begin
               len = goal - items_sent;
            end
            // most streams are closed; some run on into the next one
            send_stream(len, $urandom_range(7) != 0);
         end
         wait_for_quiet();
      end

      // Pressure: hold the output side off while bytes keep coming so the
      // encoder fills and stalls its input. A full 57-byte line followed by
      // an end gives the automatic line end and then a blank line.
      write_reg(b64ml_pkg::CSR_TEXT_MODE, 1'b0);
      write_reg(b64ml_pkg::CSR_CRLF_LINE_END, 1'b1);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < 57; i++) begin
         send_item(b64ml_pkg::KIND_DATA, 8'($urandom_range(255)));
      end
      send_item(b64ml_pkg::KIND_END, 8'h00);
      wait_for_quiet();

      if (fail_count == 0 && chars_pending == 0) begin
         $display("base64_mime_line_encoder: match");
      end else begin
         $display("base64_mime_line_encoder: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("base64_mime_line_encoder: mismatch");
      $finish;
   end

endmodule

### base64_mime_line_encoder.f
src/b64ml_pkg.sv
src/b64ml_front.sv
src/b64ml_queue.sv
src/b64ml_back.sv
src/base64_mime_line_encoder.sv
sim/base64_mime_line_encoder_checker.sv
sim/testbench.sv
